// ----- src/pfa_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfa_pkg
// Shared types and constants of the page frame allocator: request, response
// and configuration payloads, operation codes and controller states.
// ----------------------------------------------------------------------------
package pfa_pkg;

  // Fixed RAM window managed by the allocator
  localparam logic [31:0] RAM_BASE       = 32'h4000_0000;
  localparam logic [31:0] RAM_LIMIT      = 32'h4800_0000;
  localparam logic [31:0] KERNEL_END_RST = 32'h4000_0000;

  typedef enum logic [1:0] {
    OP_INIT  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FREE  = 2'd2
  } pfa_op_e;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } pfa_state_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] address;
  } pfa_req_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] page_address;
    logic [15:0] used_count;
    logic [15:0] free_count;
  } pfa_rsp_t;

  typedef struct packed {
    logic [31:0] kernel_end;
  } pfa_cfg_t;

endpackage
`default_nettype wire

// ----- src/pfa_chan_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfa_chan_if
// Valid/ready channel carrying one payload of a configurable type.
// ----------------------------------------------------------------------------
interface pfa_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- src/pfa_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfa_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that holds its data while no read is issued.
// ----------------------------------------------------------------------------
module pfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ----- src/pfa_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfa_core
// Allocation engine: region registers, counters, free-page stack and
// per-page free marks in synchronous RAM, read-modify-write sequencer and
// response register.
// ----------------------------------------------------------------------------
module pfa_core #(
  parameter int PAGE_BYTES = 4096,
  parameter int NUM_PAGES  = 32768
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [31:0] kernel_end_i,
  pfa_chan_if.sink         req_i,
  pfa_chan_if.source       rsp_o
);
  import pfa_pkg::*;

  localparam int SH    = $clog2(PAGE_BYTES);
  localparam int IDX_W = $clog2(NUM_PAGES);
  localparam int CNT_W = $clog2(NUM_PAGES + 1);
  localparam logic [32:0]      PB_M1   = 33'(PAGE_BYTES - 1);
  localparam logic [CNT_W-1:0] NP_CNT  = CNT_W'(NUM_PAGES);
  localparam logic [31:0]      NP_WORD = 32'(NUM_PAGES);

  pfa_state_e state_q, state_d;

  logic             ready_q, ready_d;
  logic [31:0]      region_start_q, region_start_d;
  logic [CNT_W-1:0] page_total_q, page_total_d;
  logic [CNT_W-1:0] bump_cnt_q, bump_cnt_d;
  logic [CNT_W-1:0] page_used_q, page_used_d;
  logic [CNT_W-1:0] stack_depth_q, stack_depth_d;

  logic [1:0]       op_q;
  logic             pre_ok_q;
  logic [IDX_W-1:0] idx_q;

  pfa_rsp_t         rsp_q, rsp_d;
  logic             rsp_valid_q, rsp_valid_d;

  logic             in_fire, out_free;
  logic [31:0]      diff_w, pidx_w;
  logic             pre_ok_w;
  logic [CNT_W-1:0] depth_m1;

  logic [32:0]      start_w;
  logic             outside_w;
  logic [31:0]      n_pages_w;
  logic [CNT_W-1:0] n_capped_w;

  logic             mark_we, mark_wdata, mark_rdata;
  logic [IDX_W-1:0] mark_waddr;
  logic             stack_we;
  logic [IDX_W-1:0] stack_rdata;
  logic [CNT_W-1:0] sel_idx;
  logic [31:0]      page_w;

  assign req_i.ready = (state_q == ST_IDLE);
  assign in_fire     = req_i.valid && req_i.ready;
  assign out_free    = !rsp_valid_q || rsp_o.ready;

  // Precheck a free request against state that holds until it executes
  assign diff_w   = req_i.data.address - region_start_q;
  assign pidx_w   = diff_w >> SH;
  assign pre_ok_w = ready_q && (req_i.data.address != 32'd0)
                    && (req_i.data.address[SH-1:0] == '0)
                    && (req_i.data.address >= region_start_q)
                    && (pidx_w < 32'(bump_cnt_q))
                    && (page_used_q != '0)
                    && (stack_depth_q < NP_CNT);
  assign depth_m1 = stack_depth_q - CNT_W'(1);

  // Round the kernel end up to a page and size the region
  assign start_w    = ({1'b0, kernel_end_i} + PB_M1) & ~PB_M1;
  assign outside_w  = (start_w < {1'b0, RAM_BASE}) || (start_w > {1'b0, RAM_LIMIT});
  assign n_pages_w  = (RAM_LIMIT - start_w[31:0]) >> SH;
  assign n_capped_w = (n_pages_w > NP_WORD) ? NP_CNT : CNT_W'(n_pages_w);

  // Free marks: read at accept, written when a request executes
  pfa_ram #(
    .WIDTH (1),
    .DEPTH (NUM_PAGES)
  ) u_mark_ram (
    .clk_i   (clk_i),
    .we_i    (mark_we),
    .waddr_i (mark_waddr),
    .wdata_i (mark_wdata),
    .re_i    (in_fire),
    .raddr_i (pidx_w[IDX_W-1:0]),
    .rdata_o (mark_rdata)
  );

  // Free-page stack: top read at accept, pushed on a good free
  pfa_ram #(
    .WIDTH (IDX_W),
    .DEPTH (NUM_PAGES)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stack_we),
    .waddr_i (stack_depth_q[IDX_W-1:0]),
    .wdata_i (idx_q),
    .re_i    (in_fire),
    .raddr_i (depth_m1[IDX_W-1:0]),
    .rdata_o (stack_rdata)
  );

  // Capture the request
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q     <= req_i.data.operation;
      pre_ok_q <= pre_ok_w;
      idx_q    <= pidx_w[IDX_W-1:0];
    end
  end

  // Sequencer and read-modify-write datapath
  always_comb begin
    state_d        = state_q;
    ready_d        = ready_q;
    region_start_d = region_start_q;
    page_total_d   = page_total_q;
    bump_cnt_d     = bump_cnt_q;
    page_used_d    = page_used_q;
    stack_depth_d  = stack_depth_q;
    rsp_d          = rsp_q;
    rsp_valid_d    = rsp_valid_q && !rsp_o.ready;
    mark_we        = 1'b0;
    mark_waddr     = idx_q;
    mark_wdata     = 1'b0;
    stack_we       = 1'b0;
    sel_idx        = bump_cnt_q;

    if (stack_depth_q != '0) begin
      sel_idx = CNT_W'(stack_rdata);
    end
    page_w = region_start_q + (32'(sel_idx) << SH);

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          state_d            = ST_IDLE;
          rsp_valid_d        = 1'b1;
          rsp_d.page_address = 32'd0;
          rsp_d.ok           = 1'b0;
          unique case (pfa_op_e'(op_q))
            OP_INIT: begin
              if (!ready_q) begin
                ready_d       = 1'b1;
                page_used_d   = '0;
                stack_depth_d = '0;
                bump_cnt_d    = '0;
                rsp_d.ok      = 1'b1;
                if (outside_w) begin
                  region_start_d = RAM_LIMIT;
                  page_total_d   = '0;
                end else begin
                  region_start_d = start_w[31:0];
                  page_total_d   = n_capped_w;
                end
              end
            end
            OP_ALLOC: begin
              if (ready_q) begin
                if (stack_depth_q != '0) begin
                  // Pop the most recently freed page
                  stack_depth_d      = depth_m1;
                  page_used_d        = page_used_q + CNT_W'(1);
                  mark_we            = 1'b1;
                  mark_waddr         = stack_rdata;
                  rsp_d.ok           = 1'b1;
                  rsp_d.page_address = page_w;
                end else if (bump_cnt_q < page_total_q) begin
                  // Advance the bump pointer, first write of this mark
                  bump_cnt_d         = bump_cnt_q + CNT_W'(1);
                  page_used_d        = page_used_q + CNT_W'(1);
                  mark_we            = 1'b1;
                  mark_waddr         = bump_cnt_q[IDX_W-1:0];
                  rsp_d.ok           = 1'b1;
                  rsp_d.page_address = page_w;
                end
              end
            end
            OP_FREE: begin
              if (pre_ok_q && !mark_rdata) begin
                mark_we       = 1'b1;
                mark_wdata    = 1'b1;
                stack_we      = 1'b1;
                stack_depth_d = stack_depth_q + CNT_W'(1);
                page_used_d   = page_used_q - CNT_W'(1);
                rsp_d.ok      = 1'b1;
              end
            end
            default: begin
              rsp_d.ok = 1'b0;
            end
          endcase
          rsp_d.used_count = 16'(page_used_d);
          rsp_d.free_count = 16'(page_total_d - page_used_d);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      ready_q        <= 1'b0;
      region_start_q <= 32'd0;
      page_total_q   <= '0;
      bump_cnt_q     <= '0;
      page_used_q    <= '0;
      stack_depth_q  <= '0;
      rsp_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      ready_q        <= ready_d;
      region_start_q <= region_start_d;
      page_total_q   <= page_total_d;
      bump_cnt_q     <= bump_cnt_d;
      page_used_q    <= page_used_d;
      stack_depth_q  <= stack_depth_d;
      rsp_valid_q    <= rsp_valid_d;
    end
  end

  // Response payload register
  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_q;

  // Every handed-out page is either in use or on the stack
  a_page_balance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, page_used_q} + {1'b0, stack_depth_q}) == {1'b0, bump_cnt_q})
    else $error("used plus stacked pages differ from bump count");

  a_bump_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bump_cnt_q <= page_total_q)
    else $error("bump count beyond region");

  a_stack_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stack_depth_q <= NP_CNT)
    else $error("free stack overflow");

  a_page_means_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q && (rsp_q.page_address != 32'd0) |-> rsp_q.ok)
    else $error("page address returned on refused request");

endmodule
`default_nettype wire

// ----- src/page_frame_allocator_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// page_frame_allocator_unit
// Page frame allocator for the RAM window 0x4000_0000 to 0x4800_0000 with
// bump allocation and a LIFO free list.
// ----------------------------------------------------------------------------
// Each request is accepted in the idle state, which issues reads of the free
// stack and free mark RAMs; the execute state reads, modifies and writes them
// back and loads the response register, holding while an earlier response is
// not yet taken. A new request is accepted only once the current one has
// executed, after the registered reads. A waiting response does not
// block acceptance of the next request. Both memories are used from reset
// with no clearing pass: a page mark is first written when the bump pointer
// hands the page out, and only pages below the bump pointer are ever checked.
// The kernel_end register may be written at any time and is sampled by init.
module page_frame_allocator_unit #(
  parameter int PAGE_BYTES = 4096,
  parameter int NUM_PAGES  = 32768
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  pfa_chan_if.sink   req_i,
  pfa_chan_if.source rsp_o,
  pfa_chan_if.sink   cfg_i
);
  import pfa_pkg::*;

  logic [31:0] kernel_end_q;

  // Take configuration writes every cycle
  assign cfg_i.ready = 1'b1;

  // Hold the kernel end register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kernel_end_q <= KERNEL_END_RST;
    end else if (cfg_i.valid) begin
      kernel_end_q <= cfg_i.data.kernel_end;
    end
  end

  pfa_core #(
    .PAGE_BYTES (PAGE_BYTES),
    .NUM_PAGES  (NUM_PAGES)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .kernel_end_i (kernel_end_q),
    .req_i        (req_i),
    .rsp_o        (rsp_o)
  );

endmodule
`default_nettype wire

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for page_frame_allocator_unit. It predicts each response
// from its own copy of the allocator state: bump pointer, LIFO of returned
// pages and per-page free marks. It drives init, allocate and free requests,
// directed first and then random. The random part is mostly well-formed
// alloc/free traffic over a small managed region, so the region runs full and
// drains again. It compares every response field by field, in order.
// ----------------------------------------------------------------------------
module tb;
  import pfa_pkg::*;

  localparam int          PAGE_BYTES   = 4096;
  localparam int          NUM_PAGES    = 32768;
  localparam logic [1:0]  OP_UNUSED    = 2'd3;
  localparam int          LIMIT_CYCLES = 200000;
  localparam int          MAX_REPORTS  = 10;

  logic clk_i;
  logic rst_ni;

  pfa_chan_if #(.payload_t(pfa_req_t)) req_if ();
  pfa_chan_if #(.payload_t(pfa_rsp_t)) rsp_if ();
  pfa_chan_if #(.payload_t(pfa_cfg_t)) cfg_if ();

  page_frame_allocator_unit #(
    .PAGE_BYTES(PAGE_BYTES),
    .NUM_PAGES (NUM_PAGES)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if.sink),
    .rsp_o (rsp_if.source),
    .cfg_i (cfg_if.sink)
  );

  // Mirror of the allocator state
  logic [31:0] kernel_end_cfg;
  bit          region_live;
  logic [31:0] region_base;
  logic [31:0] bump_ptr;
  int unsigned pages_total;
  int unsigned pages_used;
  int unsigned free_lifo[$];
  bit          freed_mark[NUM_PAGES];

  // Responses owed by the block, oldest first
  pfa_rsp_t    awaited_rsp_q[$];

  bit          quiet_phase;
  int          stall_left;
  int unsigned cycle_cnt;
  int unsigned mismatch_cnt;
  int unsigned request_cnt;
  int unsigned grant_cnt;
  int unsigned return_cnt;
  int unsigned refusal_cnt;
  int unsigned cfg_write_cnt;

  // Clock: 10 ns period
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles, %0d responses outstanding", cycle_cnt,
               awaited_rsp_q.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // Work out the response to one request and advance the mirror state
  function automatic pfa_rsp_t page_request_outcome(pfa_req_t item);
    pfa_rsp_t          rsp;
    longint unsigned   start64;
    longint unsigned   span;
    longint unsigned   region_end;
    int unsigned       idx;
    logic [31:0]       addr;
    rsp  = '0;
    addr = item.address;
    case (item.operation)
      OP_INIT: begin
        if (!region_live) begin
          // Round up without wrapping, then clip to the window
          start64 = (longint'(kernel_end_cfg) + PAGE_BYTES - 1) &
                    ~(longint'(PAGE_BYTES) - 1);
          region_live = 1'b1;
          pages_used  = 0;
          free_lifo.delete();
          if (start64 < RAM_BASE || start64 > RAM_LIMIT) begin
            region_base = RAM_LIMIT;
            bump_ptr    = RAM_LIMIT;
            pages_total = 0;
          end else begin
            span = (longint'(RAM_LIMIT) - start64) / PAGE_BYTES;
            if (span > NUM_PAGES) span = NUM_PAGES;
            region_base = start64[31:0];
            bump_ptr    = start64[31:0];
            pages_total = span;
          end
          rsp.ok = 1'b1;
        end
      end
      OP_ALLOC: begin
        if (region_live) begin
          if (free_lifo.size() > 0) begin
            idx = free_lifo.pop_back();
            freed_mark[idx]  = 1'b0;
            rsp.page_address = region_base + idx * PAGE_BYTES;
            rsp.ok           = 1'b1;
            pages_used++;
          end else begin
            region_end = longint'(region_base) + longint'(pages_total) * PAGE_BYTES;
            if (longint'(bump_ptr) < region_end) begin
              rsp.page_address = bump_ptr;
              rsp.ok           = 1'b1;
              bump_ptr         = bump_ptr + PAGE_BYTES;
              pages_used++;
            end
          end
        end
      end
      OP_FREE: begin
        if (region_live && addr != 0 && (addr & (PAGE_BYTES - 1)) == 0 &&
            addr >= region_base && addr < bump_ptr && addr < RAM_LIMIT &&
            pages_used != 0) begin
          idx = (addr - region_base) / PAGE_BYTES;
          if (idx < NUM_PAGES && !freed_mark[idx] && free_lifo.size() < NUM_PAGES) begin
            freed_mark[idx] = 1'b1;
            free_lifo.push_back(idx);
            pages_used--;
            rsp.ok = 1'b1;
          end
        end
      end
      default: ;
    endcase
    if (rsp.ok && item.operation == OP_ALLOC) grant_cnt++;
    if (rsp.ok && item.operation == OP_FREE) return_cnt++;
    if (!rsp.ok) refusal_cnt++;
    rsp.used_count = 16'(pages_used);
    rsp.free_count = 16'(pages_total - pages_used);
    return rsp;
  endfunction

  // Check each response against the oldest expectation
  always @(posedge clk_i) begin : rsp_check
    pfa_rsp_t want;
    pfa_rsp_t got;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      got = rsp_if.data;
      if (awaited_rsp_q.size() == 0) begin
        if (mismatch_cnt < MAX_REPORTS)
          $display("%0t: unexpected response ok=%0b page=%08h used=%0d free=%0d",
                   $realtime, got.ok, got.page_address, got.used_count, got.free_count);
        mismatch_cnt++;
      end else begin
        want = awaited_rsp_q.pop_front();
        if (got.ok !== want.ok || got.page_address !== want.page_address ||
            got.used_count !== want.used_count || got.free_count !== want.free_count) begin
          if (mismatch_cnt < MAX_REPORTS)
            $display("%0t: response mismatch: exp ok=%0b page=%08h used=%0d free=%0d, got ok=%0b page=%08h used=%0d free=%0d",
                     $realtime, want.ok, want.page_address, want.used_count,
                     want.free_count, got.ok, got.page_address, got.used_count,
                     got.free_count);
          mismatch_cnt++;
        end
      end
    end
  end

  // Stall the response channel in random bursts
  always @(negedge clk_i) begin
    if (quiet_phase) begin
      rsp_if.ready = 1'b1;
      stall_left   = 0;
    end else if (stall_left > 0) begin
      rsp_if.ready = 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 5) == 0) begin
      rsp_if.ready = 1'b0;
      stall_left   = $urandom_range(0, 7);
    end else begin
      rsp_if.ready = 1'b1;
    end
  end

  // Send one request, with an occasional gap ahead of it
  task automatic issue_request(input logic [1:0] op, input logic [31:0] addr);
    pfa_req_t item;
    item.operation = op;
    item.address   = addr;
    if (!quiet_phase && $urandom_range(0, 4) == 0) begin
      @(negedge clk_i);
      req_if.valid = 1'b0;
      repeat ($urandom_range(0, 7)) @(negedge clk_i);
    end
    @(negedge clk_i);
    req_if.valid = 1'b1;
    req_if.data  = item;
    do @(posedge clk_i); while (!req_if.ready);
    awaited_rsp_q.push_back(page_request_outcome(item));
    request_cnt++;
  endtask

  // Drop valid and wait until every response is back
  task automatic wait_drained();
    @(negedge clk_i);
    req_if.valid = 1'b0;
    while (awaited_rsp_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_kernel_end(input logic [31:0] value);
    wait_drained();
    @(negedge clk_i);
    cfg_if.valid = 1'b1;
    cfg_if.data  = pfa_cfg_t'(value);
    do @(posedge clk_i); while (!cfg_if.ready);
    kernel_end_cfg = value;
    cfg_write_cnt++;
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  // Pick a page that is currently handed out, if one can be found
  function automatic logic [31:0] live_page();
    int unsigned span;
    int unsigned idx;
    if (bump_ptr <= region_base) return region_base;
    span = (bump_ptr - region_base) / PAGE_BYTES;
    for (int i = 0; i < 8; i++) begin
      idx = $urandom_range(0, span - 1);
      if (!freed_mark[idx]) return region_base + idx * PAGE_BYTES;
    end
    return region_base;
  endfunction

  // Pick a free address that should be refused
  function automatic logic [31:0] bad_free_addr();
    case ($urandom_range(0, 6))
      0: return 32'h0;
      1: return live_page() + $urandom_range(1, PAGE_BYTES - 1);
      2: return region_base - PAGE_BYTES * $urandom_range(1, 4);
      3: return bump_ptr;
      4: begin
        if (free_lifo.size() > 0)
          return region_base +
                 free_lifo[$urandom_range(0, free_lifo.size() - 1)] * PAGE_BYTES;
        return $urandom;
      end
      5: return $urandom;
      default: return ($urandom_range(0, 1) == 0) ? RAM_LIMIT : 32'hFFFF_F000;
    endcase
  endfunction

  // Allocate and free before init, then set up a small region
  task automatic test_before_init();
    int unsigned pages;
    int unsigned slack;
    issue_request(OP_ALLOC, 32'h0);
    issue_request(OP_FREE, RAM_BASE);
    issue_request(OP_UNUSED, 32'h0);
    write_kernel_end(32'hFFFF_FFFF);
    write_kernel_end(32'h0);
    // Round-up lands exactly on a page boundary a few dozen pages below the end
    pages = $urandom_range(24, 64);
    slack = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, PAGE_BYTES - 1);
    write_kernel_end(RAM_LIMIT - pages * PAGE_BYTES - slack);
  endtask

  task automatic test_init_once();
    issue_request(OP_INIT, $urandom);
    issue_request(OP_INIT, 32'hFFFF_FFFF);
  endtask

  // LIFO reuse, double free and several refused-free cases
  task automatic test_lifo_and_refusals();
    logic [31:0] base;
    base = region_base;
    repeat (3) issue_request(OP_ALLOC, $urandom);
    issue_request(OP_FREE, base + PAGE_BYTES);
    issue_request(OP_FREE, base + PAGE_BYTES);
    issue_request(OP_ALLOC, 32'hFFFF_FFFF);
    issue_request(OP_FREE, base);
    issue_request(OP_FREE, base + 1);
    issue_request(OP_FREE, base - PAGE_BYTES);
    issue_request(OP_FREE, bump_ptr);
    issue_request(OP_FREE, 32'h0);
    issue_request(OP_FREE, 32'hFFFF_F000);
    issue_request(OP_UNUSED, 32'hFFFF_FFFF);
    issue_request(OP_ALLOC, 32'h0);
  endtask

  // Mostly well-formed alloc/free traffic with some noise
  task automatic test_random_traffic(input int unsigned count, input int unsigned alloc_pct);
    int unsigned roll;
    repeat (count) begin
      roll = $urandom_range(0, 99);
      if (roll < 2) issue_request(OP_INIT, $urandom);
      else if (roll < 4) issue_request(OP_UNUSED, $urandom);
      else if (roll < 4 + alloc_pct) issue_request(OP_ALLOC, $urandom);
      else if (roll < 88) issue_request(OP_FREE, live_page());
      else issue_request(OP_FREE, bad_free_addr());
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    req_if.valid   = 1'b0;
    req_if.data    = '0;
    rsp_if.ready   = 1'b0;
    cfg_if.valid   = 1'b0;
    cfg_if.data    = '0;
    quiet_phase    = 1'b0;
    stall_left     = 0;
    cycle_cnt      = 0;
    mismatch_cnt   = 0;
    request_cnt    = 0;
    grant_cnt      = 0;
    return_cnt     = 0;
    refusal_cnt    = 0;
    cfg_write_cnt  = 0;
    kernel_end_cfg = KERNEL_END_RST;
    region_live    = 1'b0;
    region_base    = '0;
    bump_ptr       = '0;
    pages_total    = 0;
    pages_used     = 0;

    // Hold reset, then release it at a falling clock edge
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_before_init();
    test_init_once();
    test_lifo_and_refusals();

    test_random_traffic(280, 60);
    write_kernel_end(32'hFFFF_FFFF);
    test_random_traffic(280, 35);
    write_kernel_end(32'h0);
    test_random_traffic(280, 55);
    write_kernel_end($urandom);
    test_random_traffic(280, 45);

    // Run the tail with no idling on either side
    quiet_phase = 1'b1;
    test_random_traffic(180, 50);

    wait_drained();
    repeat (10) @(posedge clk_i);

    $display("Sent %0d requests: %0d pages granted, %0d returned, %0d refused",
             request_cnt, grant_cnt, return_cnt, refusal_cnt);
    $display("Region of %0d pages at %08h, %0d kernel_end writes, %0d mismatches",
             pages_total, region_base, cfg_write_cnt, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
